// File: sv/rls_pkg.sv
// shared types, constants and saturation helpers of the rls estimator
`timescale 1ns / 1ps
package rls_pkg;

	localparam int DIM = 4;
	localparam int DW = 32;
	localparam int PW = 48;
	localparam int WW = 64;
	localparam int NW = 96;
	localparam int LAMW = 16;
	localparam int DIAGW = 31;
	localparam int TDW = 160;
	localparam logic [LAMW-1:0] LAM_RST = 16'd32440;
	localparam logic [DIAGW-1:0] DIAG_RST = 31'd65536;

	typedef enum logic [1:0] {
		REG_LAMBDA = 2'd0,
		REG_DIAG   = 2'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_TX,
		OP_PXJ,
		OP_PXI,
		OP_XU,
		OP_K,
		OP_TH,
		OP_PD1,
		OP_PD2
	} lane_op_t;

	typedef struct packed {
		logic start;
		lane_op_t op;
		logic [1:0] j;
	} lane_cmd_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_PART,
		M_SIGN,
		M_OUT
	} mul_st_t;

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_OUT
	} div_st_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_MERGE,
		S_OUT
	} top_st_t;

	function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
		logic signed [63:0] r;
		if (&v[127:63] || ~|v[127:63]) begin
			r = v[63:0];
		end else begin
			r = v[127] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [63:0] sadd64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] ssub64(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] satw32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (&v[63:31] || ~|v[63:31]) begin
			r = v[31:0];
		end else begin
			r = v[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [47:0] satw48(input logic signed [63:0] v);
		logic signed [47:0] r;
		if (&v[63:47] || ~|v[63:47]) begin
			r = v[47:0];
		end else begin
			r = v[63] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: sv/rls_mul.sv
// signed 64 by 64 multiplier from four 32 by 32 partial products, shift and saturate
`timescale 1ns / 1ps
module rls_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] a,
	input  logic signed [63:0] b,
	input  logic sh32,
	output logic done,
	output logic signed [63:0] res
);
	import rls_pkg::*;

	mul_st_t st_q, st_d;
	logic [63:0] ma_q, mb_q;
	logic neg_q, sh_q;
	logic [127:0] acc_q;
	logic [1:0] cnt_q;
	logic [31:0] pa, pb;
	logic [63:0] pp;
	logic [127:0] ppx;
	logic signed [127:0] sh_v;

	assign pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp = pa * pb;

	always_comb begin
		case (cnt_q)
			2'd0: ppx = {64'b0, pp};
			2'd3: ppx = {pp, 64'b0};
			default: ppx = {32'b0, pp, 32'b0};
		endcase
	end

	assign sh_v = sh_q ? ($signed(acc_q) >>> 32) : ($signed(acc_q) >>> 16);
	assign res = sat64(sh_v);
	assign done = (st_q == M_OUT);

	always_comb begin
		st_d = st_q;
		case (st_q)
			M_IDLE: if (start) st_d = M_PART;
			M_PART: if (cnt_q == 2'd3) st_d = M_SIGN;
			M_SIGN: st_d = M_OUT;
			M_OUT: st_d = M_IDLE;
			default: st_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_IDLE;
			cnt_q <= 2'd0;
		end else begin
			st_q <= st_d;
			if (st_q == M_PART) cnt_q <= cnt_q + 2'd1;
			else cnt_q <= 2'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			M_IDLE: begin
				if (start) begin
					ma_q <= a[63] ? 64'(-a) : a;
					mb_q <= b[63] ? 64'(-b) : b;
					neg_q <= a[63] ^ b[63];
					sh_q <= sh32;
					acc_q <= 128'b0;
				end
			end
			M_PART: acc_q <= acc_q + ppx;
			M_SIGN: if (neg_q) acc_q <= 128'(-acc_q);
			default: ;
		endcase
	end

endmodule

// File: sv/rls_div.sv
// restoring divider, 96-bit signed numerator by 64-bit divisor, one bit a cycle
`timescale 1ns / 1ps
module rls_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [95:0] num,
	input  logic signed [63:0] den,
	output logic done,
	output logic signed [63:0] res
);
	import rls_pkg::*;

	div_st_t st_q, st_d;
	logic [95:0] n_q, q_q;
	logic [64:0] r_q;
	logic [63:0] ud_q;
	logic neg_q;
	logic [6:0] cnt_q;
	logic [64:0] rr;
	logic ge;
	logic signed [96:0] qs;

	assign rr = {r_q[63:0], n_q[95]};
	assign ge = (rr >= {1'b0, ud_q});
	assign qs = neg_q ? 97'(-{1'b0, q_q}) : {1'b0, q_q};
	assign res = sat64({{31{qs[96]}}, qs});
	assign done = (st_q == D_OUT);

	always_comb begin
		st_d = st_q;
		case (st_q)
			D_IDLE: if (start) st_d = D_RUN;
			D_RUN: if (cnt_q == 7'(NW - 1)) st_d = D_OUT;
			D_OUT: st_d = D_IDLE;
			default: st_d = D_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
			cnt_q <= 7'd0;
		end else begin
			st_q <= st_d;
			if (st_q == D_RUN) cnt_q <= cnt_q + 7'd1;
			else cnt_q <= 7'd0;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					n_q <= num[95] ? 96'(-num) : num;
					ud_q <= den[63] ? 64'(-den) : den;
					neg_q <= num[95] ^ den[63];
					r_q <= 65'b0;
					q_q <= 96'b0;
				end
			end
			D_RUN: begin
				n_q <= {n_q[94:0], 1'b0};
				r_q <= ge ? (rr - {1'b0, ud_q}) : rr;
				q_q <= {q_q[94:0], ge};
			end
			default: ;
		endcase
	end

endmodule

// File: sv/rls_lane.sv
// one lane: a row of the covariance, one parameter and its own multiplier and divider
`timescale 1ns / 1ps
module rls_lane (
	input  logic clk,
	input  logic arst_n,
	input  logic [1:0] lane_idx,
	input  rls_pkg::lane_cmd_t cmd,
	input  logic capture,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] x_bcast,
	input  logic signed [31:0] err,
	input  logic signed [63:0] den,
	input  logic den_pos,
	input  logic [16:0] lam,
	input  logic signed [63:0] v_in,
	input  logic load,
	input  logic [30:0] diag,
	output logic done,
	output logic signed [63:0] res,
	output logic signed [31:0] theta
);
	import rls_pkg::*;

	logic signed [31:0] x_q, theta_q;
	logic signed [63:0] u_q, k_q, diff_q, res_q;
	logic signed [47:0] p_q [DIM];
	lane_op_t op_q;
	logic [1:0] j_q;
	logic done_q;

	logic signed [63:0] ma, mb;
	logic msh, mstart, mdone, dstart, ddone;
	logic signed [63:0] mres, dres;
	logic signed [95:0] dnum;
	logic signed [63:0] dden;
	logic signed [63:0] p_sel;

	assign p_sel = {{16{p_q[cmd.j][47]}}, p_q[cmd.j]};

	always_comb begin
		ma = 64'sd0;
		mb = 64'sd0;
		msh = 1'b0;
		mstart = 1'b0;
		dnum = {u_q, 32'b0};
		dden = den;
		dstart = 1'b0;
		case (cmd.op)
			OP_TX: begin
				ma = {{32{theta_q[31]}}, theta_q};
				mb = {{32{x_q[31]}}, x_q};
				mstart = cmd.start;
			end
			OP_PXJ: begin
				ma = p_sel;
				mb = {{32{x_bcast[31]}}, x_bcast};
				mstart = cmd.start;
			end
			OP_PXI: begin
				ma = p_sel;
				mb = {{32{x_q[31]}}, x_q};
				mstart = cmd.start;
			end
			OP_XU: begin
				ma = {{32{x_q[31]}}, x_q};
				mb = u_q;
				mstart = cmd.start;
			end
			OP_TH: begin
				ma = k_q;
				mb = {{32{err[31]}}, err};
				msh = 1'b1;
				mstart = cmd.start;
			end
			OP_PD1: begin
				ma = k_q;
				mb = v_in;
				msh = 1'b1;
				mstart = cmd.start;
			end
			OP_K: begin
				dstart = cmd.start && den_pos;
			end
			OP_PD2: begin
				dnum = {{17{diff_q[63]}}, diff_q, 15'b0};
				dden = {47'b0, lam};
				dstart = cmd.start;
			end
			default: ;
		endcase
	end

	rls_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb), .sh32(msh),
		.done(mdone), .res(mres)
	);

	rls_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .res(dres)
	);

	assign done = done_q;
	assign res = res_q;
	assign theta = theta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			op_q <= OP_TX;
			j_q <= 2'd0;
			theta_q <= 32'sd0;
			for (int j = 0; j < DIM; j++) begin
				p_q[j] <= (2'(j) == lane_idx) ? {1'b0, DIAG_RST, 16'b0} : 48'sd0;
			end
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				op_q <= cmd.op;
				j_q <= cmd.j;
				if (cmd.op == OP_K && !den_pos) done_q <= 1'b1;
			end
			if (load) begin
				theta_q <= 32'sd0;
				for (int j = 0; j < DIM; j++) begin
					p_q[j] <= (2'(j) == lane_idx) ? {1'b0, diag, 16'b0} : 48'sd0;
				end
			end
			if (mdone) begin
				done_q <= 1'b1;
				if (op_q == OP_TH) theta_q <= satw32(sadd64({{32{theta_q[31]}}, theta_q}, mres));
			end
			if (ddone) begin
				done_q <= 1'b1;
				if (op_q == OP_PD2) p_q[j_q] <= satw48(dres);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			x_q <= x_in;
			u_q <= 64'sd0;
		end
		if (cmd.start && cmd.op == OP_K && !den_pos) k_q <= 64'sd0;
		if (mdone) begin
			case (op_q)
				OP_PXJ: u_q <= sadd64(u_q, mres);
				OP_PD1: diff_q <= ssub64({{16{p_q[j_q][47]}}, p_q[j_q]}, mres);
				default: res_q <= mres;
			endcase
		end
		if (ddone && op_q == OP_K) k_q <= dres;
	end

endmodule

// File: sv/rls_estimator_update_top.sv
// top level of the recursive least squares estimator: sequencer, merge stage and ports
`timescale 1ns / 1ps
// Recursive least squares estimator with exponential forgetting.
// Input channel s_*: one item holds four Q16.16 regressor elements and the
// observed output. Output channel m_*: one item holds the prediction error
// and the four updated Q16.16 parameters.
// Four lanes, one per covariance row, each with a 64x64 multiplier built from
// 32x32 partial products and a 96-step divider. A merge stage sums the lane
// results in row order with saturation. From accept to result the sequencer
// makes five divider runs in turn (one gain, four covariance columns). One
// item is worked at a time; s_tready is high only while the sequencer is idle.
// The result sits in an output register; while the receiver stalls the next
// item is still taken and worked, and only its final write waits for the slot.
// Reset loads lambda 32440, diagonal 1.0, zero parameters and a diagonal
// covariance. A write on cfg_* to index 0 (lambda) or 1 (diagonal) stores the
// value and reloads the same state in the cycle after; other indexes do nothing.
module rls_estimator_update_top (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// regressor_0, regressor_1, regressor_2, regressor_3, observed_output
	input  logic [rls_pkg::TDW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// prediction_error, estimate_0, estimate_1, estimate_2, estimate_3
	output logic [rls_pkg::TDW-1:0] m_tdata,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [rls_pkg::DIAGW-1:0] cfg_data
);
	import rls_pkg::*;

	top_st_t st_q, st_d;
	lane_op_t step_q, step_d;
	logic [1:0] j_q, j_d;
	logic [1:0] m_cnt_q;
	logic [LAMW-1:0] lam_q;
	logic [DIAGW-1:0] diag_q;
	logic load_q;
	logic signed [31:0] x_q [DIM];
	logic signed [31:0] y_q, e_q;
	logic signed [63:0] v_q [DIM];
	logic signed [63:0] sum_q, den_q;
	logic m_tvalid_q;
	logic [TDW-1:0] m_tdata_q;

	logic accept, lane_done, out_go;
	logic [DIM-1:0] dones;
	logic signed [63:0] lres [DIM];
	logic signed [31:0] lth [DIM];
	logic [16:0] lam_eff;
	logic signed [63:0] lam_term, sum_next;
	lane_cmd_t cmd;

	assign s_tready = (st_q == S_IDLE) && !load_q;
	assign accept = s_tvalid && s_tready;
	assign lane_done = &dones;
	assign out_go = !m_tvalid_q || m_tready;
	assign lam_eff = (lam_q == '0) ? 17'd1 : {1'b0, lam_q};
	assign lam_term = {30'b0, lam_eff, 17'b0};
	assign sum_next = sadd64(sum_q, lres[m_cnt_q]);

	assign cmd.start = (st_q == S_ISSUE);
	assign cmd.op = step_q;
	assign cmd.j = j_q;

	genvar g;
	generate
		for (g = 0; g < DIM; g++) begin : g_lane
			rls_lane u_lane (
				.clk(clk), .arst_n(arst_n), .lane_idx(2'(g)), .cmd(cmd),
				.capture(accept), .x_in(s_tdata[g*DW +: DW]), .x_bcast(x_q[j_q]),
				.err(e_q), .den(den_q), .den_pos(!den_q[63] && |den_q),
				.lam(lam_eff), .v_in(v_q[j_q]), .load(load_q), .diag(diag_q),
				.done(dones[g]), .res(lres[g]), .theta(lth[g])
			);
		end
	endgenerate

	always_comb begin
		st_d = st_q;
		step_d = step_q;
		j_d = j_q;
		case (st_q)
			S_IDLE: begin
				if (accept) begin
					st_d = S_ISSUE;
					step_d = OP_TX;
					j_d = 2'd0;
				end
			end
			S_ISSUE: st_d = S_WAIT;
			S_WAIT: begin
				if (lane_done) begin
					st_d = S_ISSUE;
					case (step_q)
						OP_TX, OP_PXI, OP_XU: st_d = S_MERGE;
						OP_PXJ: step_d = OP_PXI;
						OP_K: step_d = OP_TH;
						OP_TH: begin
							step_d = OP_PD1;
							j_d = 2'd0;
						end
						OP_PD1: step_d = OP_PD2;
						OP_PD2: begin
							if (j_q == 2'd3) begin
								st_d = S_OUT;
							end else begin
								step_d = OP_PD1;
								j_d = j_q + 2'd1;
							end
						end
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_MERGE: begin
				if (m_cnt_q == 2'd3) begin
					st_d = S_ISSUE;
					case (step_q)
						OP_TX: begin
							step_d = OP_PXJ;
							j_d = 2'd0;
						end
						OP_PXI: begin
							if (j_q == 2'd3) begin
								step_d = OP_XU;
								j_d = 2'd0;
							end else begin
								step_d = OP_PXJ;
								j_d = j_q + 2'd1;
							end
						end
						OP_XU: step_d = OP_K;
						default: st_d = S_IDLE;
					endcase
				end
			end
			S_OUT: if (out_go) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			step_q <= OP_TX;
			j_q <= 2'd0;
			m_cnt_q <= 2'd0;
			lam_q <= LAM_RST;
			diag_q <= DIAG_RST;
			load_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			step_q <= step_d;
			j_q <= j_d;
			load_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					REG_LAMBDA: begin
						lam_q <= cfg_data[LAMW-1:0];
						load_q <= 1'b1;
					end
					REG_DIAG: begin
						diag_q <= cfg_data;
						load_q <= 1'b1;
					end
					default: ;
				endcase
			end
			if (st_q == S_MERGE) m_cnt_q <= m_cnt_q + 2'd1;
			else m_cnt_q <= 2'd0;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (st_q == S_OUT && out_go) m_tvalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < DIM; i++) x_q[i] <= s_tdata[i*DW +: DW];
			y_q <= s_tdata[DIM*DW +: DW];
		end
		if (st_q == S_WAIT) sum_q <= 64'sd0;
		if (st_q == S_MERGE) begin
			sum_q <= sum_next;
			if (m_cnt_q == 2'd3) begin
				case (step_q)
					OP_TX: e_q <= satw32(ssub64({{32{y_q[31]}}, y_q}, sum_next));
					OP_PXI: v_q[j_q] <= sum_next;
					OP_XU: den_q <= sadd64(sum_next, lam_term);
					default: ;
				endcase
			end
		end
		if (st_q == S_OUT && out_go) begin
			m_tdata_q <= {lth[3], lth[2], lth[1], lth[0], e_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule
